// ===== sv/rtcc_pkg.sv =====
`default_nettype none

package rtcc_pkg;

   // command codes carried on req_tuser
   typedef enum logic [1:0] {
      CMD_TICK     = 2'd0,
      CMD_SET_ALL  = 2'd1,
      CMD_SET_TIME = 2'd2,
      CMD_SET_DATE = 2'd3
   } cmd_type;

   localparam int unsigned MS_PER_SEC   = 1000;
   localparam int unsigned SEC_PER_MIN  = 60;
   localparam int unsigned MIN_PER_HOUR = 60;
   localparam int unsigned HOUR_PER_DAY = 24;
   localparam int unsigned MONTHS       = 12;
   localparam int unsigned YEAR_LAST    = 99;
   localparam int unsigned DAY_MAX      = 31;

   localparam int unsigned REQ_TDATA_W = 64;
   localparam int unsigned REQ_TUSER_W = 2;
   localparam int unsigned RSP_TDATA_W = 48;
   localparam int unsigned RSP_TUSER_W = 1;

   // calendar state, also the payload of one result
   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
      logic [9:0] ms;
   } cal_type;

   // one request as held in the input register
   typedef struct packed {
      cmd_type     command;
      logic [15:0] ms_count;
      logic [7:0]  set_year;
      logic [7:0]  set_month;
      logic [7:0]  set_day;
      logic [7:0]  set_hour;
      logic [7:0]  set_minute;
      logic [7:0]  set_second;
   } req_type;

   // days in a month; two-digit years are leap when divisible by four
   function automatic logic [4:0] month_length(input logic [6:0] year,
                                               input logic [3:0] month);
      logic [4:0] len;
      unique case (month) inside
         4'd2:                    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== sv/rtc_calendar_counter.sv =====
`default_nettype none

// channel | dir | transaction content
// req_*   | in  | tuser: command; tdata: ms_count, set_year .. set_second
// rsp_*   | out | tuser: accepted; tdata: cur_ms .. cur_year, zero padded
//
// one transaction per clock sustained while rsp_tready stays high; a result passes
// through the input register, then the result register
// the calendar update is one combinational pass between the two registers
// reset (synchronous, high) sets 00:00:00.000 on day 1, month 1, year 0
// a stalled result holds the pipe; req_tready stays high while the input
// register is empty or is moving into the result register this cycle
module rtc_calendar_counter (
   input  logic                               clock,
   input  logic                               reset,
   // slave side: requests
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] ms_count, [23:16] set_year, [31:24] set_month, [39:32] set_day,
   // [47:40] set_hour, [55:48] set_minute, [63:56] set_second
   input  logic [rtcc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] command
   input  logic [rtcc_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // master side: results
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [9:0] cur_ms, [15:10] cur_second, [21:16] cur_minute, [26:22] cur_hour,
   // [31:27] cur_day, [35:32] cur_month, [42:36] cur_year, [47:43] zero
   output logic [rtcc_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [0] accepted
   output logic [rtcc_pkg::RSP_TUSER_W-1:0]   rsp_tuser
);

   // input register
   rtcc_pkg::req_type   req_ff;
   logic                req_valid_ff;
   // calendar state
   rtcc_pkg::cal_type   cal_ff;
   rtcc_pkg::cal_type   cal_in;
   // result register
   logic                rsp_valid_ff;
   rtcc_pkg::cal_type   rsp_cal_ff;
   logic                rsp_ok_ff;
   logic                ok_in;

   logic                advance;
   logic                req_take;

   // request in the input register moves on when the result slot frees up
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   rtcc_next u_next (
      .req (req_ff),
      .cur (cal_ff),
      .nxt (cal_in),
      .ok  (ok_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff       <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         cal_ff             <= '{year: 7'd0, month: 4'd1, day: 5'd1, hour: 5'd0,
                                 minute: 6'd0, second: 6'd0, ms: 10'd0};
      end else begin
         if (req_take) begin
            req_valid_ff <= 1'b1;
         end else if (advance) begin
            req_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            cal_ff       <= cal_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff.command    <= rtcc_pkg::cmd_type'(req_tuser[1:0]);
         req_ff.ms_count   <= req_tdata[15:0];
         req_ff.set_year   <= req_tdata[23:16];
         req_ff.set_month  <= req_tdata[31:24];
         req_ff.set_day    <= req_tdata[39:32];
         req_ff.set_hour   <= req_tdata[47:40];
         req_ff.set_minute <= req_tdata[55:48];
         req_ff.set_second <= req_tdata[63:56];
      end
      if (advance) begin
         rsp_cal_ff <= cal_in;
         rsp_ok_ff  <= ok_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ok_ff;
   assign rsp_tdata  = {5'd0,
                        rsp_cal_ff.year,
                        rsp_cal_ff.month,
                        rsp_cal_ff.day,
                        rsp_cal_ff.hour,
                        rsp_cal_ff.minute,
                        rsp_cal_ff.second,
                        rsp_cal_ff.ms};

endmodule

`default_nettype wire

// ===== sv/rtcc_next.sv =====
`default_nettype none

// next calendar state and accept flag for one request
module rtcc_next (
   input  var rtcc_pkg::req_type req,
   input  var rtcc_pkg::cal_type cur,
   output var rtcc_pkg::cal_type nxt,
   output logic                  ok
);

   logic [16:0]         ms_sum;
   logic                sec_carry;
   logic [5:0]          day_inc;
   logic [4:0]          len;
   logic                date_ok;
   logic                time_ok;
   rtcc_pkg::cal_type   tick;

   assign ms_sum  = {7'd0, cur.ms} + {1'b0, req.ms_count};
   assign day_inc = {1'b0, cur.day} + 6'd1;
   assign len     = rtcc_pkg::month_length(cur.year, cur.month);

   assign date_ok = (req.set_year <= 8'(rtcc_pkg::YEAR_LAST))
                 && (req.set_month >= 8'd1) && (req.set_month <= 8'(rtcc_pkg::MONTHS))
                 && (req.set_day >= 8'd1) && (req.set_day <= 8'(rtcc_pkg::DAY_MAX));
   assign time_ok = (req.set_hour < 8'(rtcc_pkg::HOUR_PER_DAY))
                 && (req.set_minute < 8'(rtcc_pkg::MIN_PER_HOUR))
                 && (req.set_second < 8'(rtcc_pkg::SEC_PER_MIN));

   // millisecond accumulate, then one-second cascade
   always_comb begin
      tick      = cur;
      sec_carry = (ms_sum >= 17'(rtcc_pkg::MS_PER_SEC));
      if (!sec_carry) begin
         tick.ms = ms_sum[9:0];
      end else begin
         tick.ms = '0;
         if (cur.second < 6'(rtcc_pkg::SEC_PER_MIN - 1)) begin
            tick.second = cur.second + 6'd1;
         end else begin
            tick.second = '0;
            if (cur.minute < 6'(rtcc_pkg::MIN_PER_HOUR - 1)) begin
               tick.minute = cur.minute + 6'd1;
            end else begin
               tick.minute = '0;
               if (cur.hour < 5'(rtcc_pkg::HOUR_PER_DAY - 1)) begin
                  tick.hour = cur.hour + 5'd1;
               end else begin
                  tick.hour = '0;
                  // day past the month length rolls to the first of next month
                  if (day_inc > {1'b0, len}) begin
                     tick.day = 5'd1;
                     if (cur.month >= 4'(rtcc_pkg::MONTHS)) begin
                        tick.month = 4'd1;
                        tick.year  = (cur.year >= 7'(rtcc_pkg::YEAR_LAST)) ? 7'd0
                                                                          : cur.year + 7'd1;
                     end else begin
                        tick.month = cur.month + 4'd1;
                     end
                  end else begin
                     tick.day = day_inc[4:0];
                  end
               end
            end
         end
      end
   end

   always_comb begin
      nxt = cur;
      ok  = 1'b1;
      case (req.command)
         rtcc_pkg::CMD_TICK: begin
            nxt = tick;
         end
         rtcc_pkg::CMD_SET_ALL: begin
            ok = date_ok && time_ok;
            if (ok) begin
               nxt.year   = req.set_year[6:0];
               nxt.month  = req.set_month[3:0];
               nxt.day    = req.set_day[4:0];
               nxt.hour   = req.set_hour[4:0];
               nxt.minute = req.set_minute[5:0];
               nxt.second = req.set_second[5:0];
            end
         end
         rtcc_pkg::CMD_SET_TIME: begin
            ok = time_ok;
            if (ok) begin
               nxt.hour   = req.set_hour[4:0];
               nxt.minute = req.set_minute[5:0];
               nxt.second = req.set_second[5:0];
            end
         end
         default: begin
            ok = date_ok;
            if (ok) begin
               nxt.year  = req.set_year[6:0];
               nxt.month = req.set_month[3:0];
               nxt.day   = req.set_day[4:0];
            end
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/rtcc_checker.sv =====
`default_nettype none

module rtcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // with the result slot empty the block always takes a request
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("not ready with empty result slot");

   // reported calendar stays in range
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         rsp_tdata[9:0] <= 10'd999 && rsp_tdata[15:10] <= 6'd59
         && rsp_tdata[21:16] <= 6'd59 && rsp_tdata[26:22] <= 5'd23
         && rsp_tdata[31:27] != 5'd0 && rsp_tdata[35:32] != 4'd0
         && rsp_tdata[35:32] <= 4'd12 && rsp_tdata[42:36] <= 7'd99
         && rsp_tdata[47:43] == 5'd0)
      else $error("calendar out of range");

endmodule

bind rtc_calendar_counter rtcc_checker u_rtcc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
